// ===== design/psr_pkg.sv =====
// ----------------------------------------------------------------------------
// psr_pkg
// shared types and constants for the point store with radius count
// ----------------------------------------------------------------------------
`default_nettype none

package psr_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int COORD_W      = 16;
  localparam int POINT_W      = 2 * COORD_W;
  localparam int RAD_W        = 24;
  localparam int RAD_SQ_W     = 2 * RAD_W;
  localparam int FRAC_SQ_W    = 16;                  // Q16.8 squared has 16 fraction bits
  localparam int LIM_W        = RAD_SQ_W - FRAC_SQ_W;
  localparam int SQ_W         = 2 * COORD_W - 1;     // x*x of a 16-bit signed value
  localparam int SUM_W        = SQ_W + 1;
  localparam int OUT_CNT_W    = 7;

  typedef enum logic [2:0] {
    ACT_PUSH = 3'd0,
    ACT_POP  = 3'd1,
    ACT_DEL  = 3'd2,
    ACT_RAD  = 3'd3,
    ACT_SRCH = 3'd4,
    ACT_LEN  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // per-cycle command to every cell of the chain
  typedef struct packed {
    logic shift_back;   // cell i takes cell i-1 (push)
    logic shift_front;  // cell i takes cell i+1 (pop, walk)
    logic wrap;         // tail cell takes the head entry during a walk
  } cell_ctl_t;

  // distance check result leaving the squaring pipeline
  typedef struct packed {
    logic valid;
    logic last;
    logic in_range;
  } dist_res_t;

endpackage

`default_nettype wire

// ===== design/psr_cell.sv =====
// ----------------------------------------------------------------------------
// psr_cell
// one slot of the point chain, loads from either neighbor or the head
// ----------------------------------------------------------------------------
`default_nettype none

module psr_cell #(
  parameter int DATA_W = psr_pkg::POINT_W
) (
  input  wire logic              clk,
  input  wire psr_pkg::cell_ctl_t ctl,
  input  wire logic              tail_sel,
  input  wire logic [DATA_W-1:0] prev_data,
  input  wire logic [DATA_W-1:0] next_data,
  input  wire logic [DATA_W-1:0] head_data,
  output logic      [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (ctl.shift_back) begin
      data_r <= prev_data;
    end else if (ctl.shift_front) begin
      // tail slot closes the ring so a full walk restores the order
      data_r <= (ctl.wrap && tail_sel) ? head_data : next_data;
    end
  end

  assign data_o = data_r;

endmodule

`default_nettype wire

// ===== design/psr_dist.sv =====
// ----------------------------------------------------------------------------
// psr_dist
// two-stage squaring pipeline, compares x*x+y*y against the radius limit
// ----------------------------------------------------------------------------
`default_nettype none

module psr_dist (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         vld_i,
  input  wire logic                         last_i,
  input  wire logic [psr_pkg::POINT_W-1:0]  point_i,
  input  wire logic [psr_pkg::LIM_W-1:0]    lim_i,
  output psr_pkg::dist_res_t                res_o
);

  logic signed [psr_pkg::COORD_W-1:0] px;
  logic signed [psr_pkg::COORD_W-1:0] py;
  logic signed [2*psr_pkg::COORD_W-1:0] prod_x;
  logic signed [2*psr_pkg::COORD_W-1:0] prod_y;
  logic [psr_pkg::SQ_W-1:0]  sq_x_r;
  logic [psr_pkg::SQ_W-1:0]  sq_y_r;
  logic [psr_pkg::SUM_W-1:0] sum;
  logic                      s1_vld_r;
  logic                      s1_last_r;
  logic                      s2_vld_r;
  logic                      s2_last_r;
  logic                      s2_inside_r;

  assign px     = point_i[psr_pkg::POINT_W-1:psr_pkg::COORD_W];
  assign py     = point_i[psr_pkg::COORD_W-1:0];
  assign prod_x = px * px;
  assign prod_y = py * py;
  assign sum    = {1'b0, sq_x_r} + {1'b0, sq_y_r};

  always_ff @(posedge clk) begin
    sq_x_r      <= prod_x[psr_pkg::SQ_W-1:0];
    sq_y_r      <= prod_y[psr_pkg::SQ_W-1:0];
    s2_inside_r <= (sum <= lim_i);
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s1_last_r <= 1'b0;
      s2_vld_r  <= 1'b0;
      s2_last_r <= 1'b0;
    end else begin
      s1_vld_r  <= vld_i;
      s1_last_r <= vld_i && last_i;
      s2_vld_r  <= s1_vld_r;
      s2_last_r <= s1_last_r;
    end
  end

  assign res_o.valid    = s2_vld_r;
  assign res_o.last     = s2_last_r;
  assign res_o.in_range = s2_inside_r;

endmodule

`default_nettype wire

// ===== design/point_store_radius_query_core.sv =====
// ----------------------------------------------------------------------------
// point_store_radius_query_core
// last-in-first-out store of signed 2-D points with radius count
// ----------------------------------------------------------------------------
// The store is a chain of CAPACITY cells, cell 0 holding the newest point.
// Push and pop shift the whole chain by one slot; they, length and any op on
// an empty store answer straight from idle. Delete, search and radius count
// walk the chain: the head entry is read every cycle while the chain rotates
// toward the front and the tail cell takes the head back, so a walk over N
// stored points leaves the order as it was. Delete simply does not feed back
// the first matching point, which closes the gap. Radius count sends each
// head entry through a two-stage squaring pipeline and answers once it has
// drained. One item is worked at a time; a new one is taken while idle once
// the result register is free or being drained. There is no clearing pass
// after reset: slots beyond the entry count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module point_store_radius_query_core #(
  parameter int CAPACITY = psr_pkg::CAPACITY_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // request channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [2:0]                  in_action,
  input  wire logic signed [15:0]          in_point_x,
  input  wire logic signed [15:0]          in_point_y,
  input  wire logic [23:0]                 in_radius,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_status,
  output logic                             out_found,
  output logic [6:0]                       out_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int PW    = psr_pkg::POINT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN
  } state_t;

  // control state
  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [CNT_W-1:0]           steps_r, steps_nxt;
  logic [CNT_W-1:0]           tally_r, tally_nxt;
  logic                       hit_r, hit_nxt;
  logic                       out_valid_r, out_valid_nxt;
  // payload
  psr_pkg::action_t           op_r, op_nxt;
  logic [PW-1:0]              key_r, key_nxt;
  logic [psr_pkg::LIM_W-1:0]  lim_r, lim_nxt;
  psr_pkg::status_t           out_status_r, out_status_nxt;
  logic                       out_found_r, out_found_nxt;
  logic [6:0]                 out_count_r, out_count_nxt;

  psr_pkg::action_t           act;
  logic [PW-1:0]              in_key;
  logic [psr_pkg::RAD_SQ_W-1:0] rad_sq;
  logic                       in_xfer;

  // chain wiring
  psr_pkg::cell_ctl_t         ctl;
  logic [PW-1:0]              cell_q [CAPACITY];
  logic [CAPACITY-1:0]        tail_sel;
  logic [IDX_W-1:0]           tail_idx;
  logic [PW-1:0]              head;
  logic                       match;
  logic                       drop;

  // distance pipeline
  logic                       dist_vld;
  logic                       dist_last;
  psr_pkg::dist_res_t         dist_res;

  // result assembly
  logic                       resp_en;
  psr_pkg::status_t           resp_status;
  logic                       resp_found;
  logic [CNT_W-1:0]           resp_cnt;
  logic [CNT_W+6:0]           resp_cnt_ext;
  logic [CNT_W-1:0]           final_tally;

  assign act      = psr_pkg::action_t'(in_action);
  assign in_key   = {in_point_x, in_point_y};
  assign rad_sq   = psr_pkg::RAD_SQ_W'(in_radius) * psr_pkg::RAD_SQ_W'(in_radius);
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_xfer  = in_valid && in_ready;

  assign head     = cell_q[0];
  assign match    = (head == key_r);
  assign tail_idx = IDX_W'(count_r - CNT_W'(1));

  // the chain of point cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [PW-1:0] prev_d;
    logic [PW-1:0] next_d;

    assign tail_sel[i] = (tail_idx == IDX_W'(i));

    if (i == 0) begin : g_first
      assign prev_d = in_key;
    end else begin : g_prev
      assign prev_d = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_d = head;
    end else begin : g_next
      assign next_d = cell_q[i+1];
    end

    psr_cell #(
      .DATA_W (PW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .tail_sel  (tail_sel[i]),
      .prev_data (prev_d),
      .next_data (next_d),
      .head_data (head),
      .data_o    (cell_q[i])
    );
  end

  psr_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (dist_vld),
    .last_i  (dist_last),
    .point_i (head),
    .lim_i   (lim_r),
    .res_o   (dist_res)
  );

  assign final_tally = tally_r + CNT_W'(dist_res.in_range);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    steps_nxt     = steps_r;
    tally_nxt     = tally_r;
    hit_nxt       = hit_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    lim_nxt       = lim_r;
    ctl           = '0;
    drop          = 1'b0;
    dist_vld      = 1'b0;
    dist_last     = 1'b0;
    resp_en       = 1'b0;
    resp_status   = psr_pkg::ST_OK;
    resp_found    = 1'b0;
    resp_cnt      = '0;

    // points inside the radius coming out of the pipeline
    if (dist_res.valid && dist_res.in_range) begin
      tally_nxt = tally_r + CNT_W'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt    = act;
          key_nxt   = in_key;
          lim_nxt   = rad_sq[psr_pkg::RAD_SQ_W-1:psr_pkg::FRAC_SQ_W];
          steps_nxt = count_r;
          hit_nxt   = 1'b0;
          tally_nxt = '0;
          case (act)
            psr_pkg::ACT_PUSH: begin
              resp_en = 1'b1;
              if (count_r == CNT_W'(CAPACITY)) begin
                resp_status = psr_pkg::ST_FULL;
              end else begin
                ctl.shift_back = 1'b1;
                count_nxt      = count_r + CNT_W'(1);
              end
            end
            psr_pkg::ACT_POP: begin
              resp_en = 1'b1;
              if (count_r == '0) begin
                resp_status = psr_pkg::ST_MISS;
              end else begin
                ctl.shift_front = 1'b1;
                count_nxt       = count_r - CNT_W'(1);
              end
            end
            psr_pkg::ACT_DEL, psr_pkg::ACT_RAD, psr_pkg::ACT_SRCH: begin
              if (count_r == '0) begin
                resp_en     = 1'b1;
                resp_status = psr_pkg::ST_MISS;
              end else begin
                state_nxt = S_WALK;
              end
            end
            psr_pkg::ACT_LEN: begin
              resp_en  = 1'b1;
              resp_cnt = count_r;
            end
            default: begin
              resp_en     = 1'b1;
              resp_status = psr_pkg::ST_MISS;
            end
          endcase
        end
      end

      S_WALK: begin
        // rotate the live ring by one, dropping the first delete match
        drop            = (op_r == psr_pkg::ACT_DEL) && match && !hit_r;
        ctl.shift_front = 1'b1;
        ctl.wrap        = !drop;
        if (drop) begin
          count_nxt = count_r - CNT_W'(1);
        end
        hit_nxt   = hit_r || match;
        steps_nxt = steps_r - CNT_W'(1);
        dist_vld  = (op_r == psr_pkg::ACT_RAD);
        dist_last = (steps_r == CNT_W'(1));
        if (steps_r == CNT_W'(1)) begin
          if (op_r == psr_pkg::ACT_RAD) begin
            state_nxt = S_DRAIN;
          end else begin
            state_nxt   = S_IDLE;
            resp_en     = 1'b1;
            resp_found  = (op_r == psr_pkg::ACT_SRCH) && (hit_r || match);
            resp_status = (hit_r || match) ? psr_pkg::ST_OK : psr_pkg::ST_MISS;
          end
        end
      end

      S_DRAIN: begin
        if (dist_res.valid && dist_res.last) begin
          state_nxt   = S_IDLE;
          resp_en     = 1'b1;
          resp_cnt    = final_tally;
          resp_status = (final_tally == '0) ? psr_pkg::ST_MISS : psr_pkg::ST_OK;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // count field wraps to its seven bits
  assign resp_cnt_ext = {7'b0, resp_cnt};

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    if (resp_en) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = resp_status;
      out_found_nxt  = resp_found;
      out_count_nxt  = resp_cnt_ext[6:0];
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    lim_r        <= lim_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      steps_r     <= '0;
      tally_r     <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      steps_r     <= steps_nxt;
      tally_r     <= tally_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_found  = out_found_r;
  assign out_count  = out_count_r;

  // entry count stays within the chain
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // a walk always has entries left to visit
  a_walk_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (steps_r != '0))
    else $error("walk with no remaining steps");

  // a push transfer into a store with room grows it by one
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (act == psr_pkg::ACT_PUSH) && (count_r < CNT_W'(CAPACITY)))
      |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("push did not add an entry");

  // found only ever goes out with status ok
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_status == psr_pkg::ST_OK))
    else $error("found flagged with bad status");

endmodule

`default_nettype wire

// ===== tb/point_store_radius_query_core_tb.sv =====
// ----------------------------------------------------------------------------
// point_store_radius_query_core_tb
// self-checking bench for the point store with radius count
// ----------------------------------------------------------------------------
// A table of directed requests covers the empty store, unused action codes,
// coordinate and radius extremes, duplicates and delete of the front match.
// Random requests then follow in phases that grow, drain or mix the store, so
// it runs full and empty many times. Every result is checked field by field,
// typed rows against the table, the rest against a behavioral store copy.
// ----------------------------------------------------------------------------
`default_nettype none

module point_store_radius_query_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psr_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1425;
  localparam int DRAIN_CYCLES = CAP + 40;
  localparam int N_DIRECTED   = 25;

  // action codes the block does not define
  localparam logic [2:0] ACT_UNUSED6 = 3'd6;
  localparam logic [2:0] ACT_UNUSED7 = 3'd7;

  // expected result of one request
  typedef struct packed {
    status_t    status;
    logic       found;
    logic [6:0] count;
  } result_t;

  localparam result_t R_OK   = '{ST_OK,   1'b0, 7'd0};
  localparam result_t R_MISS = '{ST_MISS, 1'b0, 7'd0};

  // one row of the directed table; want is used only when typed is set
  typedef struct {
    logic [2:0]         code;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [23:0]        rad;
    bit                 typed;
    result_t            want;
  } req_row_t;

  // request mixes used by the random part
  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_MIXED} mix_t;

  localparam logic [2:0] MIX_CODES [8] = '{ACT_PUSH, ACT_POP, ACT_DEL, ACT_RAD,
                                           ACT_SRCH, ACT_LEN, ACT_UNUSED6,
                                           ACT_UNUSED7};
  // weights in percent, same order as MIX_CODES
  localparam int MIX_WEIGHT [3][8] = '{'{60,  8,  8,  8,  8, 5, 2, 1},
                                       '{10, 35, 25, 10, 10, 7, 2, 1},
                                       '{30, 15, 15, 15, 15, 7, 2, 1}};

  // --------------------------------------------------------------------------
  // clock, reset and block ports
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic [2:0]         in_action  = ACT_PUSH;
  logic signed [15:0] in_point_x = '0;
  logic signed [15:0] in_point_y = '0;
  logic [23:0]        in_radius  = '0;

  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic [1:0]         out_status;
  logic               out_found;
  logic [6:0]         out_count;

  always #5 clk = ~clk;

  point_store_radius_query_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_action  (in_action),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .in_radius  (in_radius),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_found  (out_found),
    .out_count  (out_count)
  );

  // --------------------------------------------------------------------------
  // bench state
  // --------------------------------------------------------------------------
  // shadow of the point chain: index 0 is the oldest point, stored_n-1 the front
  logic [31:0] stored_pts [CAP];
  int          stored_n = 0;

  result_t     pending_results [$];   // expected results in transfer order
  int          mismatches = 0;
  bit          no_idle    = 1'b0;     // phase with neither gaps nor stalls

  // --------------------------------------------------------------------------
  // store behavior: applies one request to the shadow and returns its result
  // --------------------------------------------------------------------------
  function automatic result_t apply_request(input logic [2:0] code,
                                            input logic signed [15:0] px,
                                            input logic signed [15:0] py,
                                            input logic [23:0] rad);
    result_t            r;
    logic [31:0]        key;
    logic signed [15:0] tx, ty;
    longint             xs, ys, lim;
    int                 hit, n;
    r   = R_OK;
    key = {px, py};
    hit = -1;
    // first match counted from the front
    for (int i = stored_n - 1; i >= 0; i--)
      if (hit < 0 && stored_pts[i] == key) hit = i;
    case (code)
      ACT_PUSH: begin
        if (stored_n >= CAP) begin
          r.status = ST_FULL;
        end else begin
          stored_pts[stored_n] = key;
          stored_n++;
        end
      end
      ACT_POP: begin
        if (stored_n == 0) r.status = ST_MISS;
        else stored_n--;
      end
      ACT_DEL: begin
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          // older points keep their order, the gap closes
          for (int i = hit; i < stored_n - 1; i++) stored_pts[i] = stored_pts[i + 1];
          stored_n--;
        end
      end
      ACT_RAD: begin
        // exact compare: (x*x + y*y) * 2^16 <= radius^2
        lim = longint'(rad) * longint'(rad);
        n   = 0;
        for (int i = 0; i < stored_n; i++) begin
          tx = stored_pts[i][31:16];
          ty = stored_pts[i][15:0];
          xs = tx;
          ys = ty;
          if ((xs * xs + ys * ys) * 65536 <= lim) n++;
        end
        r.count = 7'(n);
        if (n == 0) r.status = ST_MISS;
      end
      ACT_SRCH: begin
        if (hit >= 0) r.found = 1'b1;
        else r.status = ST_MISS;
      end
      ACT_LEN: begin
        r.count = 7'(stored_n);
      end
      default: begin
        r.status = ST_MISS;
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // random choices
  // --------------------------------------------------------------------------
  // idle length: mostly none, often short, now and then long
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [2:0] pick_action(input mix_t mix);
    int roll, acc;
    roll = $urandom_range(0, 99);
    acc  = 0;
    for (int k = 0; k < 8; k++) begin
      acc += MIX_WEIGHT[mix][k];
      if (roll < acc) return MIX_CODES[k];
    end
    return ACT_LEN;
  endfunction

  // stored points often, so delete and search hit; the rest spread wide
  function automatic void pick_point(output logic signed [15:0] px,
                                     output logic signed [15:0] py);
    logic signed [15:0] corner [5];
    logic [31:0]        p;
    int                 roll;
    corner = '{16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sh7fff};
    roll   = $urandom_range(0, 99);
    if (roll < 40 && stored_n > 0) begin
      p  = stored_pts[$urandom_range(0, stored_n - 1)];
      px = p[31:16];
      py = p[15:0];
    end else if (roll < 60) begin
      px = 16'($signed($urandom_range(0, 600)) - 300);
      py = 16'($signed($urandom_range(0, 600)) - 300);
    end else if (roll < 90) begin
      px = 16'($urandom);
      py = 16'($urandom);
    end else begin
      px = corner[$urandom_range(0, 4)];
      py = corner[$urandom_range(0, 4)];
    end
  endfunction

  // full range, scaled down, or right at the distance of a stored point
  function automatic logic [23:0] pick_radius();
    logic [31:0]        p;
    logic signed [15:0] tx, ty;
    longint             xs, ys, rr;
    int                 roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return 24'($urandom);
    if (roll < 75 || stored_n == 0) return 24'($urandom) >> $urandom_range(0, 23);
    p  = stored_pts[$urandom_range(0, stored_n - 1)];
    tx = p[31:16];
    ty = p[15:0];
    xs = tx;
    ys = ty;
    rr = longint'($rtoi($sqrt(real'(xs * xs + ys * ys)) * 256.0));
    rr = rr + $urandom_range(0, 2) - 1;
    if (rr < 0) rr = 0;
    if (rr > 24'hffffff) rr = 24'hffffff;
    return 24'(rr);
  endfunction

  // --------------------------------------------------------------------------
  // request side: one call per transfer, valid held until in_ready
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [2:0] code,
                              input logic signed [15:0] px,
                              input logic signed [15:0] py,
                              input logic [23:0] rad,
                              input bit typed,
                              input result_t want);
    int      gap;
    result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= code;
    in_point_x <= px;
    in_point_y <= py;
    in_radius  <= rad;
    do @(posedge clk); while (!in_ready);
    // transfer at this edge: the shadow store moves along in step
    predicted = apply_request(code, px, py, rad);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // --------------------------------------------------------------------------
  // result side: random stalls, field by field compare
  // --------------------------------------------------------------------------
  initial begin
    int      stall;
    result_t want;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing pending: status %0d found %0d count %0d",
                 out_status, out_found, out_count);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
          if (out_found !== want.found) begin
            $error("found mismatch: expected %0d, got %0d", want.found, out_found);
            mismatches++;
          end
          if (out_count !== want.count) begin
            $error("count mismatch: expected %0d, got %0d", want.count, out_count);
            mismatches++;
          end
        end
        // the stall clock runs free, so stalls land on any phase of a walk
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // directed table: empty store, unused codes, extremes, duplicates
  // --------------------------------------------------------------------------
  req_row_t directed_rows [N_DIRECTED] = '{
    // empty store
    '{ACT_LEN,     16'sd0,     16'sd0,     24'd0,       1'b1, R_OK},
    '{ACT_POP,     16'sd0,     16'sd0,     24'd0,       1'b1, R_MISS},
    '{ACT_DEL,     16'sd5,     16'sd5,     24'd0,       1'b1, R_MISS},
    '{ACT_SRCH,    16'sd5,     16'sd5,     24'd0,       1'b1, R_MISS},
    '{ACT_RAD,     16'sd0,     16'sd0,     24'hffffff,  1'b1, R_MISS},
    // unused action codes
    '{ACT_UNUSED6, 16'sd0,     16'sd0,     24'd0,       1'b1, R_MISS},
    '{ACT_UNUSED7, -16'sd1,    -16'sd1,    24'hffffff,  1'b1, R_MISS},
    // coordinate extremes
    '{ACT_PUSH,    16'sh8000,  16'sh8000,  24'd0,       1'b1, R_OK},
    '{ACT_PUSH,    16'sh7fff,  16'sh7fff,  24'd0,       1'b1, R_OK},
    '{ACT_PUSH,    16'sd0,     16'sd0,     24'd0,       1'b1, R_OK},
    '{ACT_PUSH,    16'sh8000,  16'sh7fff,  24'd0,       1'b1, R_OK},
    '{ACT_PUSH,    -16'sd1,    16'sd1,     24'd0,       1'b1, R_OK},
    '{ACT_LEN,     16'sd0,     16'sd0,     24'd0,       1'b1, '{ST_OK, 1'b0, 7'd5}},
    // largest radius takes every point, zero radius only the origin
    '{ACT_RAD,     16'sd0,     16'sd0,     24'hffffff,  1'b1, '{ST_OK, 1'b0, 7'd5}},
    '{ACT_RAD,     16'sd0,     16'sd0,     24'd0,       1'b1, '{ST_OK, 1'b0, 7'd1}},
    // just short of and just past sqrt(2)
    '{ACT_RAD,     16'sd0,     16'sd0,     24'd362,     1'b0, R_OK},
    '{ACT_RAD,     16'sd0,     16'sd0,     24'd363,     1'b0, R_OK},
    // search hit and miss, delete hit and miss
    '{ACT_SRCH,    16'sh7fff,  16'sh7fff,  24'd0,       1'b1, '{ST_OK, 1'b1, 7'd0}},
    '{ACT_SRCH,    16'sh7fff,  16'sh8000,  24'd0,       1'b1, R_MISS},
    '{ACT_DEL,     16'sd0,     16'sd0,     24'd0,       1'b1, R_OK},
    '{ACT_DEL,     16'sd0,     16'sd0,     24'd0,       1'b1, R_MISS},
    // duplicate point: delete takes the front copy, pop the older one
    '{ACT_PUSH,    -16'sd1,    16'sd1,     24'd0,       1'b1, R_OK},
    '{ACT_DEL,     -16'sd1,    16'sd1,     24'd0,       1'b1, R_OK},
    '{ACT_POP,     16'sd0,     16'sd0,     24'd0,       1'b1, R_OK},
    '{ACT_LEN,     16'sd0,     16'sd0,     24'd0,       1'b1, '{ST_OK, 1'b0, 7'd3}}
  };

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [2:0]         code;
    logic signed [15:0] px, py;
    logic [23:0]        rad;
    mix_t               mix;
    int                 issued, span, phase_no;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].code, directed_rows[i].px, directed_rows[i].py,
                   directed_rows[i].rad, directed_rows[i].typed, directed_rows[i].want);

    // random phases: growing runs the store into full, shrinking empties it
    issued   = 0;
    phase_no = 0;
    while (issued < RANDOM_ITEMS) begin
      mix     = mix_t'($urandom_range(0, 2));
      span    = $urandom_range(40, 160);
      no_idle = ($urandom_range(0, 3) == 0);
      // every third phase, hold off until the block has drained every result
      if (phase_no % 3 == 0) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      for (int k = 0; k < span && issued < RANDOM_ITEMS; k++) begin
        code = pick_action(mix);
        pick_point(px, py);
        rad = pick_radius();
        send_request(code, px, py, rad, 1'b0, R_OK);
        issued++;
      end
      phase_no++;
    end
    in_valid <= 1'b0;
    no_idle  = 1'b0;

    // wait for the last results, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // hang guard
  // --------------------------------------------------------------------------
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
